// ===== rtl/core/source_address_checksum_table_top_assert.svh =====
// Assertion macros for the source-address checksum table.
// Included by the top level; each macro expects clk and rst in scope.
`ifndef SOURCE_ADDRESS_CHECKSUM_TABLE_TOP_ASSERT_SVH
`define SOURCE_ADDRESS_CHECKSUM_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SACT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SACT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sactbl_pkg.sv =====
// Shared types and constants for the source-address checksum table.
// Used by sactbl_cell, source_address_checksum_table_top, sactbl_checker and the testbench; no dependencies.
package sactbl_pkg;

  // Table geometry.
  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Field widths.
  localparam int KEY_W         = 16;
  localparam int PAN_W         = 16;
  localparam int PSIZE_W       = 6;
  localparam int SADDR_W       = 16;
  localparam int EADDR_W       = 64;
  localparam int ENTRY_INDEX_W = 5;
  localparam int CFG_DATA_W    = 16;

  // Width that holds both a cell number and a partition size for comparison.
  localparam int CNT_W = ((IDX_W > PSIZE_W) ? IDX_W : PSIZE_W) + 1;

  // Register reset values.
  localparam logic [PAN_W-1:0]   PAN_ID_RESET    = '0;
  localparam logic [PSIZE_W-1:0] PSIZE_RESET     = PSIZE_W'(32);

  // Request functions.
  typedef enum logic [1:0] {
    FUNC_ADD_SHORT   = 2'd0,
    FUNC_CLEAR_SHORT = 2'd1,
    FUNC_ADD_EXT     = 2'd2,
    FUNC_CLEAR_EXT   = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_PAN_ID         = 1'b0,
    REG_PARTITION_SIZE = 1'b1
  } reg_idx_t;

  // Request payload.
  typedef struct packed {
    func_t              func;
    logic [SADDR_W-1:0] saddr;
    logic [EADDR_W-1:0] eaddr;
  } sactbl_req_t;

  // Response payload.
  typedef struct packed {
    status_t                  status;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [KEY_W-1:0]         key;
  } sactbl_rsp_t;

  // Token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic             active;
    logic             is_clear;
    logic [KEY_W-1:0] key;
    logic             found;
    logic [IDX_W-1:0] idx;
  } sactbl_tok_t;

endpackage

// ===== rtl/core/sactbl_cell.sv =====
// One table entry: a stored key, its valid bit and one stage of the token chain.
// Depends on sactbl_pkg.
module sactbl_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [sactbl_pkg::IDX_W-1:0]   cell_num,
  input  logic [sactbl_pkg::PSIZE_W-1:0] partition_size,
  input  sactbl_pkg::sactbl_tok_t    tok_in,
  output sactbl_pkg::sactbl_tok_t    tok_out
);
  import sactbl_pkg::*;

  logic             valid;
  logic [KEY_W-1:0] key;
  logic             in_range;
  logic             add_hit;
  logic             clr_hit;
  sactbl_tok_t      tok_next;

  // This entry takes part only when it lies below the partition size.
  assign in_range = CNT_W'(cell_num) < CNT_W'(partition_size);

  // An add claims the first free entry; a clear takes the first matching one.
  always_comb begin
    add_hit = tok_in.active && !tok_in.found && in_range && !tok_in.is_clear && !valid;
    clr_hit = tok_in.active && !tok_in.found && in_range && tok_in.is_clear && valid &&
              (key == tok_in.key);
  end

  // Mark the token once an entry has handled it.
  always_comb begin
    tok_next = tok_in;
    if (add_hit || clr_hit) begin
      tok_next.found = 1'b1;
      tok_next.idx   = cell_num;
    end
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (add_hit) begin
      valid <= 1'b1;
    end else if (clr_hit) begin
      valid <= 1'b0;
    end
  end

  // Stored key, written only by an add.
  always_ff @(posedge clk) begin
    if (add_hit) begin
      key <= tok_in.key;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/core/source_address_checksum_table_top.sv =====
// Top level of the source-address checksum table: key adder, cell chain, response stage.
// Depends on sactbl_pkg, sactbl_cell and source_address_checksum_table_top_assert.svh.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | sactbl_req_t: func, saddr, eaddr
//   rsp     | out       | rsp_valid/rsp_stall | sactbl_rsp_t: status, entry_index, key
//   cfg     | in        | cfg_we              | cfg_index, cfg_data
//
// A response is built in order: the key adder works in the accepting cycle, the token is
// registered at the chain head and then passes through each cell in turn, and the response
// register loads the result. One request is in the chain at a time, so a new request is
// taken only once the token has left the last cell and no response waits in hold.
// Reset clears all valid bits at once, sets pan_id to 0 and partition_size to 32.
// A stalled response waits in a holding register; the chain then takes no new request.
`include "source_address_checksum_table_top_assert.svh"

module source_address_checksum_table_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  sactbl_pkg::sactbl_req_t        req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output sactbl_pkg::sactbl_rsp_t        rsp,
  input  logic                           cfg_we,
  input  sactbl_pkg::reg_idx_t           cfg_index,
  input  logic [sactbl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sactbl_pkg::*;

  logic [PAN_W-1:0]   pan_id;
  logic [PSIZE_W-1:0] partition_size;

  logic               req_accept;
  logic               chain_busy;
  logic               hold_valid;
  sactbl_rsp_t        hold;
  logic               out_free;
  logic               tok_exit;
  sactbl_rsp_t        exit_rsp;
  logic               is_clear;
  logic               is_ext;
  logic [KEY_W-1:0]   ext_sum;
  logic [KEY_W-1:0]   req_key;

  sactbl_tok_t        tok [ENTRIES+1];
  logic [ENTRIES:0]   tok_active;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_id         <= PAN_ID_RESET;
      partition_size <= PSIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAN_ID:         pan_id         <= cfg_data[PAN_W-1:0];
        REG_PARTITION_SIZE: partition_size <= cfg_data[PSIZE_W-1:0];
        default:            ;
      endcase
    end
  end

  // Request handshake: one request in flight, none while a response waits in hold.
  assign req_stall  = chain_busy || hold_valid;
  assign req_accept = req_valid && !req_stall;

  // Checksum key: 16-bit wrapping sum of pan_id and the address words.
  always_comb begin
    is_clear = (req.func == FUNC_CLEAR_SHORT) || (req.func == FUNC_CLEAR_EXT);
    is_ext   = (req.func == FUNC_ADD_EXT) || (req.func == FUNC_CLEAR_EXT);
    ext_sum  = (req.eaddr[15:0] + req.eaddr[31:16]) +
               (req.eaddr[47:32] + req.eaddr[63:48]);
    req_key  = pan_id + (is_ext ? ext_sum : req.saddr);
  end

  // Chain head: the accepted request becomes a token.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok[0].active <= 1'b0;
    end else begin
      tok[0].active   <= req_accept;
      tok[0].is_clear <= is_clear;
      tok[0].key      <= req_key;
      tok[0].found    <= 1'b0;
      tok[0].idx      <= '0;
    end
  end

  // Row of entry cells.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    sactbl_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .cell_num       (IDX_W'(i)),
      .partition_size (partition_size),
      .tok_in         (tok[i]),
      .tok_out        (tok[i+1])
    );
  end

  for (genvar i = 0; i <= ENTRIES; i++) begin : g_active
    assign tok_active[i] = tok[i].active;
  end

  // Response built from the token that leaves the last cell.
  always_comb begin
    tok_exit             = tok[ENTRIES].active;
    exit_rsp.key         = tok[ENTRIES].key;
    exit_rsp.entry_index = tok[ENTRIES].found ? ENTRY_INDEX_W'(tok[ENTRIES].idx) : '0;
    if (tok[ENTRIES].found) begin
      exit_rsp.status = ST_OK;
    end else if (tok[ENTRIES].is_clear) begin
      exit_rsp.status = ST_NOTFOUND;
    end else begin
      exit_rsp.status = ST_NOSPACE;
    end
  end

  // Chain occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain_busy <= 1'b0;
    end else if (req_accept) begin
      chain_busy <= 1'b1;
    end else if (tok_exit) begin
      chain_busy <= 1'b0;
    end
  end

  assign out_free = !rsp_valid || !rsp_stall;

  // Holding register for a response that finds the output stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (tok_exit && !out_free) begin
      hold_valid <= 1'b1;
    end else if (hold_valid && out_free) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_exit && !out_free) begin
      hold <= exit_rsp;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      priority if (hold_valid && out_free) begin
        rsp_valid <= 1'b1;
      end else if (tok_exit && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (hold_valid && out_free) begin
      rsp <= hold;
    end else if (tok_exit && out_free) begin
      rsp <= exit_rsp;
    end
  end

  // Checks on chain occupancy and the holding register.
  `SACT_ASSERT_NOW(a_one_token, chain_busy, $onehot(tok_active), "chain must hold one token")
  `SACT_ASSERT_NOW(a_empty_chain, !chain_busy, tok_active == '0, "idle chain holds a token")
  `SACT_ASSERT_NOW(a_hold_free, tok_exit, !hold_valid, "token left chain while hold full")
  `SACT_ASSERT_NEXT(a_head_load, req_accept, tok[0].active, "accepted request not in chain")

endmodule

// ===== sim/sactbl_checker.sv =====
// Response checker for the source-address checksum table.
// Watches the request, response and register channels and keeps its own copy of the table.
// Depends on sactbl_pkg for the payload types, codes and table geometry.
module sactbl_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  input  logic                              req_stall,
  input  sactbl_pkg::sactbl_req_t           req,
  input  logic                              rsp_valid,
  input  logic                              rsp_stall,
  input  sactbl_pkg::sactbl_rsp_t           rsp,
  input  logic                              cfg_we,
  input  sactbl_pkg::reg_idx_t              cfg_index,
  input  logic [sactbl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                mismatch_count,
  output int                                expected_pending
);
  import sactbl_pkg::*;

  // Shadow copy of the registers and of the match table.
  logic [PAN_W-1:0]   pan_id_q;
  logic [PSIZE_W-1:0] psize_q;
  logic [KEY_W-1:0]   stored_key [ENTRIES];
  logic [ENTRIES-1:0] stored_valid;

  // Responses still owed by the block, oldest first.
  sactbl_rsp_t pending_rsp_q[$];

  // Compute the key, search the usable part of the table and apply the add or clear.
  function automatic sactbl_rsp_t predict_table_response(sactbl_req_t item);
    logic [KEY_W+1:0] sum;
    int               limit;
    int               hit;
    logic             is_clear;
    sactbl_rsp_t      res;
    sum = (KEY_W+2)'(pan_id_q);
    if (item.func == FUNC_ADD_EXT || item.func == FUNC_CLEAR_EXT) begin
      for (int w = 0; w < 4; w++) begin
        sum += item.eaddr[16*w +: 16];
      end
    end else begin
      sum += item.saddr;
    end
    res.key = sum[KEY_W-1:0];

    // A partition larger than the table just means the whole table.
    limit = (int'(psize_q) > ENTRIES) ? ENTRIES : int'(psize_q);
    is_clear = (item.func == FUNC_CLEAR_SHORT || item.func == FUNC_CLEAR_EXT);
    hit = -1;
    for (int i = 0; i < limit && hit < 0; i++) begin
      if (is_clear ? (stored_valid[i] && stored_key[i] == res.key) : !stored_valid[i]) begin
        hit = i;
      end
    end

    if (hit < 0) begin
      res.status      = is_clear ? ST_NOTFOUND : ST_NOSPACE;
      res.entry_index = '0;
    end else begin
      res.status      = ST_OK;
      res.entry_index = ENTRY_INDEX_W'(hit);
      if (is_clear) begin
        stored_valid[hit] = 1'b0;
      end else begin
        stored_key[hit]   = res.key;
        stored_valid[hit] = 1'b1;
      end
    end
    return res;
  endfunction

  // Track configuration, predict on each accepted request, compare each accepted response.
  always @(posedge clk) begin
    sactbl_rsp_t want;
    if (rst) begin
      pan_id_q     = PAN_ID_RESET;
      psize_q      = PSIZE_RESET;
      stored_valid = '0;
      pending_rsp_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PAN_ID:         pan_id_q = cfg_data[PAN_W-1:0];
          REG_PARTITION_SIZE: psize_q  = cfg_data[PSIZE_W-1:0];
          default: ;
        endcase
      end

      if (req_valid && !req_stall) begin
        pending_rsp_q.push_back(predict_table_response(req));
      end

      if (rsp_valid && !rsp_stall) begin
        if (pending_rsp_q.size() == 0) begin
          $error("unexpected response: status %0d, entry_index %0d, key 0x%04h",
                 rsp.status, rsp.entry_index, rsp.key);
          mismatch_count++;
        end else begin
          want = pending_rsp_q.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            mismatch_count++;
          end
          if (rsp.entry_index !== want.entry_index) begin
            $error("entry_index: expected %0d, actual %0d", want.entry_index, rsp.entry_index);
            mismatch_count++;
          end
          if (rsp.key !== want.key) begin
            $error("key: expected 0x%04h, actual 0x%04h", want.key, rsp.key);
            mismatch_count++;
          end
        end
      end
    end
    expected_pending = pending_rsp_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Testbench top for the source-address checksum table: clock, reset, stimulus and verdict.
// Instantiates source_address_checksum_table_top and sactbl_checker; uses sactbl_pkg.
module testbench;
  import sactbl_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int RANDOM_ITEMS   = 750;
  localparam int POOL_DEPTH     = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  sactbl_req_t           req       = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  sactbl_rsp_t           rsp;
  logic                  cfg_we    = 1'b0;
  reg_idx_t              cfg_index = REG_PAN_ID;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatch_count;
  int expected_pending;
  int rsp_count;
  bit sender_no_gaps;

  // Addresses added recently, reused for clears and duplicate adds.
  sactbl_req_t added_pool[$];

  always #HALF_PERIOD clk = ~clk;

  source_address_checksum_table_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sactbl_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req              (req),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .rsp              (rsp),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .expected_pending (expected_pending)
  );

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SADDR_W-1:0] rand_short();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SADDR_W'($urandom);
  endfunction

  function automatic logic [EADDR_W-1:0] rand_ext();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic sactbl_req_t make_req(func_t f, logic [SADDR_W-1:0] sa,
                                           logic [EADDR_W-1:0] ea);
    sactbl_req_t r;
    r.func  = f;
    r.saddr = sa;
    r.eaddr = ea;
    return r;
  endfunction

  // Offer one request, hold it until accepted, then idle for a random gap.
  task automatic send_request(sactbl_req_t item);
    int gap;
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
    gap = sender_no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering requests and wait until every response has come back.
  task automatic quiesce();
    if (req_valid) req_valid <= 1'b0;
    @(negedge clk);
    while (expected_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Count accepted responses so the receiver knows when to apply back-pressure.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) rsp_count <= rsp_count + 1;
  end

  // Receiver: random stalls, quiet stretches, and two long holds while requests keep coming.
  initial begin : receiver
    int stall_left;
    int quiet_left;
    int hold_count;
    int next_hold_at;
    stall_left   = 0;
    quiet_left   = 0;
    hold_count   = 0;
    next_hold_at = 150;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (hold_count < 2 && rsp_count >= next_hold_at) begin
          stall_left   = HOLD_CYCLES;
          hold_count++;
          next_hold_at = 450;
        end else if (quiet_left > 0) begin
          quiet_left--;
        end else if ($urandom_range(0, 199) == 0) begin
          quiet_left = $urandom_range(100, 400);
        end else if ($urandom_range(0, 99) < (rsp_valid ? 40 : 4)) begin
          stall_left = pick_gap();
        end
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // End the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    sactbl_req_t           item;
    logic [CFG_DATA_W-1:0] data;
    logic [PSIZE_W-1:0]    psize;
    int                    random_sent;
    int                    phase_len;
    int                    add_pct;
    int                    j;

    sender_no_gaps = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Extreme addresses under the reset configuration, duplicate keys, lowest-match clears.
    send_request(make_req(FUNC_ADD_SHORT,   16'h0000, rand_ext()));
    send_request(make_req(FUNC_ADD_SHORT,   16'hFFFF, rand_ext()));
    send_request(make_req(FUNC_ADD_EXT,     rand_short(), 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_req(FUNC_ADD_EXT,     rand_short(), 64'h0000_0000_0000_0000));
    send_request(make_req(FUNC_CLEAR_SHORT, 16'h0000, rand_ext()));
    send_request(make_req(FUNC_CLEAR_EXT,   rand_short(), 64'h0000_0000_0000_0000));
    send_request(make_req(FUNC_CLEAR_SHORT, 16'h0000, rand_ext()));
    send_request(make_req(FUNC_CLEAR_EXT,   rand_short(), 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_req(FUNC_CLEAR_SHORT, 16'hFFFF, rand_ext()));

    // Zero partition: adds find no space and clears find nothing.
    quiesce();
    write_register(REG_PAN_ID, 16'hFFFF);
    write_register(REG_PARTITION_SIZE, 16'h0000);
    send_request(make_req(FUNC_ADD_SHORT,   16'h0001, rand_ext()));
    send_request(make_req(FUNC_CLEAR_SHORT, 16'h0001, rand_ext()));

    // One usable entry; the key wraps to zero.
    quiesce();
    write_register(REG_PARTITION_SIZE, 16'h0001);
    send_request(make_req(FUNC_ADD_SHORT, 16'h0001, rand_ext()));
    send_request(make_req(FUNC_ADD_EXT,   rand_short(), 64'h0001_0000_0000_0000));
    send_request(make_req(FUNC_CLEAR_EXT, rand_short(), 64'h0001_0000_0000_0000));

    // Partition far beyond the table, with every data bit set.
    quiesce();
    write_register(REG_PARTITION_SIZE, 16'hFFFF);
    send_request(make_req(FUNC_ADD_EXT,     rand_short(), 64'h8000_8000_8000_8000));
    send_request(make_req(FUNC_CLEAR_SHORT, 16'h0000, rand_ext()));

    // Partition just above the table: duplicate adds are cleared lowest first.
    quiesce();
    write_register(REG_PAN_ID, 16'h0000);
    write_register(REG_PARTITION_SIZE, 16'hFFE1);
    send_request(make_req(FUNC_ADD_SHORT,   16'hFFFF, rand_ext()));
    send_request(make_req(FUNC_ADD_SHORT,   16'hFFFF, rand_ext()));
    send_request(make_req(FUNC_CLEAR_SHORT, 16'hFFFF, rand_ext()));
    send_request(make_req(FUNC_CLEAR_SHORT, 16'hFFFF, rand_ext()));
    send_request(make_req(FUNC_CLEAR_SHORT, 16'hFFFF, rand_ext()));

    // Random phases: each picks a partition, sometimes a new PAN id, and an add/clear mix.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      quiesce();
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       data = '0;
          1:       data = '1;
          default: data = CFG_DATA_W'($urandom);
        endcase
        write_register(REG_PAN_ID, data);
      end
      case ($urandom_range(0, 7))
        0:       psize = '0;
        1:       psize = PSIZE_W'(1);
        2:       psize = PSIZE_W'($urandom_range(2, 6));
        3:       psize = PSIZE_W'($urandom_range(7, 31));
        4:       psize = PSIZE_W'(ENTRIES);
        5:       psize = PSIZE_W'($urandom_range(33, 62));
        6:       psize = '1;
        default: psize = PSIZE_W'($urandom_range(0, 63));
      endcase
      data = CFG_DATA_W'($urandom);
      data[PSIZE_W-1:0] = psize;
      write_register(REG_PARTITION_SIZE, data);

      sender_no_gaps = ($urandom_range(0, 3) == 0);
      add_pct   = $urandom_range(30, 80);
      phase_len = $urandom_range(20, 60);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 99) < add_pct) begin
          // Add: mostly fresh addresses, sometimes one already in the table.
          if (added_pool.size() > 0 && $urandom_range(0, 4) == 0) begin
            item = added_pool[$urandom_range(0, added_pool.size() - 1)];
          end else begin
            item = make_req($urandom_range(0, 1) ? FUNC_ADD_EXT : FUNC_ADD_SHORT,
                            rand_short(), rand_ext());
          end
          added_pool.push_back(item);
          if (added_pool.size() > POOL_DEPTH) void'(added_pool.pop_front());
        end else begin
          // Clear: mostly an address added before, otherwise noise.
          if (added_pool.size() > 0 && $urandom_range(0, 9) < 7) begin
            j    = $urandom_range(0, added_pool.size() - 1);
            item = added_pool[j];
            added_pool.delete(j);
            item.func = (item.func == FUNC_ADD_EXT) ? FUNC_CLEAR_EXT : FUNC_CLEAR_SHORT;
          end else begin
            item = make_req($urandom_range(0, 1) ? FUNC_CLEAR_EXT : FUNC_CLEAR_SHORT,
                            rand_short(), rand_ext());
          end
        end
        send_request(item);
        random_sent++;
      end
    end

    // Drain and give the verdict.
    if (req_valid) req_valid <= 1'b0;
    wait (expected_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
